/* hw/rtl/mqd_pkg.sv */
// shared types and constants for the multi-queue work-stealing deque
// no dependencies; used by every module under hw/rtl
`timescale 1ns / 1ps

package mqd_pkg;

  localparam int HANDLE_IO_W = 32;
  localparam int QID_IO_W    = 4;
  localparam int QCOUNT_W    = 5;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  typedef enum logic [1:0] {
    MODE_PUSH_HEAD = 2'd0,
    MODE_POP_HEAD  = 2'd1,
    MODE_PUSH_TAIL = 2'd2,
    MODE_POP_TAIL  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOQUEUE = 2'd3
  } status_t;

  typedef enum logic {
    REG_QUEUE_COUNT = 1'b0,
    REG_UNUSED      = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic    wr;
    logic    rd;
    status_t status;
  } cmd_ctrl_t;

endpackage

/* hw/rtl/mqd_front.sv */
// front end: classifies each request and updates per-queue head, tail and count
// depends on mqd_pkg
`timescale 1ns / 1ps

module mqd_front #(
  parameter int NUM_QUEUES   = 16,
  parameter int QUEUE_DEPTH  = 64,
  parameter int HANDLE_WIDTH = 32,
  parameter int QIDX_W       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  parameter int IDX_W        = $clog2(QUEUE_DEPTH),
  parameter int CNT_W        = $clog2(QUEUE_DEPTH + 1),
  parameter int ADDR_W       = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            acc,
  input  mqd_pkg::mode_t                  mode,
  input  logic [mqd_pkg::QID_IO_W-1:0]    queue_id,
  input  logic [mqd_pkg::HANDLE_IO_W-1:0] task_handle,
  input  logic [mqd_pkg::QCOUNT_W-1:0]    queue_count,
  output mqd_pkg::cmd_ctrl_t              ctrl,
  output logic [ADDR_W-1:0]               addr,
  output logic [HANDLE_WIDTH-1:0]         handle
);

  logic [IDX_W-1:0] head [NUM_QUEUES];
  logic [IDX_W-1:0] tail [NUM_QUEUES];
  logic [CNT_W-1:0] count [NUM_QUEUES];

  logic [QIDX_W-1:0] qi;
  logic              qok;
  logic [IDX_W-1:0]  h, t, h_prev, h_next, t_prev, t_next, slot;
  logic [CNT_W-1:0]  n;
  logic              full, empty;
  logic [IDX_W-1:0]  head_next, tail_next;
  logic [CNT_W-1:0]  count_next;
  logic              upd;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);

  assign qi  = QIDX_W'(queue_id);
  assign qok = ({1'b0, queue_id} < queue_count) && (7'(queue_id) < 7'(NUM_QUEUES));
  assign h   = head[qi];
  assign t   = tail[qi];
  assign n   = count[qi];
  assign full  = (n == CNT_W'(QUEUE_DEPTH));
  assign empty = (n == '0);

  assign h_prev = (h == '0) ? LAST_SLOT : h - 1'b1;
  assign h_next = (h == LAST_SLOT) ? '0 : h + 1'b1;
  assign t_prev = (t == '0) ? LAST_SLOT : t - 1'b1;
  assign t_next = (t == LAST_SLOT) ? '0 : t + 1'b1;

  always_comb begin
    ctrl       = '{wr: 1'b0, rd: 1'b0, status: mqd_pkg::ST_OK};
    slot       = h;
    head_next  = h;
    tail_next  = t;
    count_next = n;
    if (!qok) begin
      ctrl.status = mqd_pkg::ST_NOQUEUE;
    end else begin
      unique case (mode)
        mqd_pkg::MODE_PUSH_HEAD: begin
          slot = h_prev;
          if (full) begin
            ctrl.status = mqd_pkg::ST_FULL;
          end else begin
            ctrl.wr    = 1'b1;
            head_next  = h_prev;
            count_next = n + 1'b1;
          end
        end
        mqd_pkg::MODE_POP_HEAD: begin
          slot = h;
          if (empty) begin
            ctrl.status = mqd_pkg::ST_EMPTY;
          end else begin
            ctrl.rd    = 1'b1;
            head_next  = h_next;
            count_next = n - 1'b1;
          end
        end
        mqd_pkg::MODE_PUSH_TAIL: begin
          slot = t;
          if (full) begin
            ctrl.status = mqd_pkg::ST_FULL;
          end else begin
            ctrl.wr    = 1'b1;
            tail_next  = t_next;
            count_next = n + 1'b1;
          end
        end
        mqd_pkg::MODE_POP_TAIL: begin
          slot = t_prev;
          if (empty) begin
            ctrl.status = mqd_pkg::ST_EMPTY;
          end else begin
            ctrl.rd    = 1'b1;
            tail_next  = t_prev;
            count_next = n - 1'b1;
          end
        end
        default: ctrl.status = mqd_pkg::ST_NOQUEUE;
      endcase
    end
  end

  assign addr   = ADDR_W'(qi) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
  assign handle = HANDLE_WIDTH'(task_handle);
  assign upd    = acc && (ctrl.wr || ctrl.rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else if (upd) begin
      head[qi]  <= head_next;
      tail[qi]  <= tail_next;
      count[qi] <= count_next;
    end
  end

  a_reject_no_access: assert property (@(posedge clk) disable iff (rst)
    acc && !qok |-> !(ctrl.wr || ctrl.rd))
    else $error("rejected queue id produced a slot access");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    acc && qok && full && (mode == mqd_pkg::MODE_PUSH_HEAD || mode == mqd_pkg::MODE_PUSH_TAIL)
    |=> count[$past(qi)] == CNT_W'(QUEUE_DEPTH))
    else $error("push into full queue changed its count");

endmodule

/* hw/rtl/mqd_cmd_fifo.sv */
// short command queue between front end and back end
// depends on mqd_pkg
`timescale 1ns / 1ps

module mqd_cmd_fifo #(
  parameter int ADDR_W       = 10,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  mqd_pkg::cmd_ctrl_t        push_ctrl,
  input  logic [ADDR_W-1:0]         push_addr,
  input  logic [HANDLE_WIDTH-1:0]   push_handle,
  output logic                      full,
  input  logic                      pop,
  output logic                      nonempty,
  output mqd_pkg::cmd_ctrl_t        pop_ctrl,
  output logic [ADDR_W-1:0]         pop_addr,
  output logic [HANDLE_WIDTH-1:0]   pop_handle
);

  mqd_pkg::cmd_ctrl_t            ctrl_q   [mqd_pkg::FIFO_DEPTH];
  logic [ADDR_W-1:0]             addr_q   [mqd_pkg::FIFO_DEPTH];
  logic [HANDLE_WIDTH-1:0]       handle_q [mqd_pkg::FIFO_DEPTH];
  logic [mqd_pkg::FIFO_PTR_W-1:0] wptr, rptr;
  logic [mqd_pkg::FIFO_CNT_W-1:0] cnt;

  assign full       = (cnt == mqd_pkg::FIFO_CNT_W'(mqd_pkg::FIFO_DEPTH));
  assign nonempty   = (cnt != '0);
  assign pop_ctrl   = ctrl_q[rptr];
  assign pop_addr   = addr_q[rptr];
  assign pop_handle = handle_q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_q[wptr]   <= push_ctrl;
      addr_q[wptr]   <= push_addr;
      handle_q[wptr] <= push_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("command queue overflow");

endmodule

/* hw/rtl/mqd_back.sv */
// back end: slot memory access and registered result stage
// depends on mqd_pkg
`timescale 1ns / 1ps

module mqd_back #(
  parameter int NUM_QUEUES   = 16,
  parameter int QUEUE_DEPTH  = 64,
  parameter int HANDLE_WIDTH = 32,
  parameter int ADDR_W       = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  input  mqd_pkg::cmd_ctrl_t              cmd_ctrl,
  input  logic [ADDR_W-1:0]               cmd_addr,
  input  logic [HANDLE_WIDTH-1:0]         cmd_handle,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [mqd_pkg::HANDLE_IO_W-1:0] popped_handle,
  output logic                            handle_valid,
  output mqd_pkg::status_t                status
);

  logic [HANDLE_WIDTH-1:0] slot_store [NUM_QUEUES * QUEUE_DEPTH];
  logic [HANDLE_WIDTH-1:0] rd_data;
  logic                    s1_valid;
  mqd_pkg::cmd_ctrl_t      s1_ctrl;
  logic                    s1_go;

  assign s1_go   = s1_valid && (!res_valid || res_ready);
  assign cmd_pop = cmd_valid && (!s1_valid || s1_go);

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (cmd_ctrl.wr) slot_store[cmd_addr] <= cmd_handle;
      rd_data <= slot_store[cmd_addr];
      s1_ctrl <= cmd_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_pop) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      popped_handle <= s1_ctrl.rd ? mqd_pkg::HANDLE_IO_W'(rd_data) : '0;
      handle_valid  <= s1_ctrl.rd;
      status        <= s1_ctrl.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  a_valid_means_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && handle_valid |-> status == mqd_pkg::ST_OK)
    else $error("handle returned with error status");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_ctrl))
    else $error("stalled memory stage lost its command");

endmodule

/* hw/rtl/multi_queue_work_stealing_deque.sv */
// top level of the multi-queue work-stealing deque
// depends on mqd_pkg, mqd_front, mqd_cmd_fifo, mqd_back
`timescale 1ns / 1ps

// usage:
//   requests enter on the s_ stream: s_tuser = mode (owner push/pop at head,
//   thief push/pop at tail), s_tdata = queue id and task handle.
//   every request gives exactly one result on the m_ stream: m_tdata =
//   popped handle and status, m_tuser = handle valid flag.
//   queue_count is written over the APB port at address 0 while idle; ids at
//   or above it report no such queue.
//   a request passes the command queue, memory stage and result register in turn.
//   throughput: one request per cycle while s_tready is high; the front end updates
//   head, tail and count of the addressed queue in the transfer cycle, the back end
//   does one slot memory access per cycle on its single port while not stalled.
//   a 4-entry command queue decouples the two; when m_tready is low results
//   back up into it and s_tready drops once it is full.
//   reset: every queue empty, queue_count 0, slot contents undefined until
//   pushed; no clearing pass.
module multi_queue_work_stealing_deque #(
  parameter int NUM_QUEUES   = 16,
  parameter int QUEUE_DEPTH  = 64,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // queue_id[3:0], task_handle[35:4], zero pad
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // popped_handle[31:0], status[33:32], zero pad
  output logic [0:0]  m_tuser,   // handle_valid[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  logic [mqd_pkg::QCOUNT_W-1:0] queue_count;
  logic                         cfg_wr;
  mqd_pkg::reg_index_t          reg_sel;

  logic                          acc;
  mqd_pkg::cmd_ctrl_t            f_ctrl, b_ctrl;
  logic [ADDR_W-1:0]             f_addr, b_addr;
  logic [HANDLE_WIDTH-1:0]       f_handle, b_handle;
  logic                          fifo_full, fifo_nonempty, fifo_pop;
  logic [mqd_pkg::HANDLE_IO_W-1:0] popped_handle;
  logic                          handle_valid;
  mqd_pkg::status_t              status;

  assign pready  = 1'b1;
  assign reg_sel = mqd_pkg::reg_index_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_count <= '0;
    end else if (cfg_wr && reg_sel == mqd_pkg::REG_QUEUE_COUNT) begin
      queue_count <= pwdata[mqd_pkg::QCOUNT_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      mqd_pkg::REG_QUEUE_COUNT: prdata = 32'(queue_count);
      default:                  prdata = '0;
    endcase
  end

  assign s_tready = !fifo_full;
  assign acc      = s_tvalid && s_tready;

  mqd_front #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH),
    .QIDX_W      (QIDX_W),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .mode       (mqd_pkg::mode_t'(s_tuser)),
    .queue_id   (s_tdata[3:0]),
    .task_handle(s_tdata[35:4]),
    .queue_count(queue_count),
    .ctrl       (f_ctrl),
    .addr       (f_addr),
    .handle     (f_handle)
  );

  mqd_cmd_fifo #(
    .ADDR_W      (ADDR_W),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (acc),
    .push_ctrl  (f_ctrl),
    .push_addr  (f_addr),
    .push_handle(f_handle),
    .full       (fifo_full),
    .pop        (fifo_pop),
    .nonempty   (fifo_nonempty),
    .pop_ctrl   (b_ctrl),
    .pop_addr   (b_addr),
    .pop_handle (b_handle)
  );

  mqd_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (fifo_nonempty),
    .cmd_pop      (fifo_pop),
    .cmd_ctrl     (b_ctrl),
    .cmd_addr     (b_addr),
    .cmd_handle   (b_handle),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .popped_handle(popped_handle),
    .handle_valid (handle_valid),
    .status       (status)
  );

  assign m_tdata = {6'b0, status, popped_handle};
  assign m_tuser = handle_valid;

endmodule

/* dv/mqd_result_check.sv */
// checker for the multi-queue work-stealing deque: watches the request, result and apb ports,
// keeps its own copy of the queue bank and compares every result transfer field by field
// depends on mqd_pkg
`timescale 1ns / 1ps

module mqd_result_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          outstanding,
  output int          fail_count
);

  localparam int BANK_SIZE  = 16;
  localparam int RING_SLOTS = 64;

  typedef struct packed {
    logic [31:0]      handle;
    logic             valid;
    mqd_pkg::status_t status;
  } deque_result_t;

  logic [31:0]   slot_mem [BANK_SIZE][RING_SLOTS];
  logic [5:0]    head_ptr [BANK_SIZE];
  logic [5:0]    tail_ptr [BANK_SIZE];
  logic [6:0]    fill     [BANK_SIZE];
  logic [4:0]    queues_in_use;
  deque_result_t results_due [$];
  int            errors;

  initial begin
    outstanding = 0;
    fail_count  = 0;
    errors      = 0;
  end

  // applies one request to the mirrored bank and returns the result it should give
  function automatic deque_result_t apply_request(mqd_pkg::mode_t op, logic [3:0] qid,
                                                  logic [31:0] handle);
    deque_result_t r;
    int unsigned   limit;
    int unsigned   q;
    r        = '0;
    r.status = mqd_pkg::ST_OK;
    limit    = (queues_in_use > BANK_SIZE) ? BANK_SIZE : queues_in_use;
    q        = qid;
    if (q >= limit) begin
      r.status = mqd_pkg::ST_NOQUEUE;
    end else begin
      case (op) inside
        mqd_pkg::MODE_PUSH_HEAD, mqd_pkg::MODE_PUSH_TAIL: begin
          if (fill[q] >= RING_SLOTS) begin
            r.status = mqd_pkg::ST_FULL;
          end else if (op == mqd_pkg::MODE_PUSH_HEAD) begin
            head_ptr[q] = head_ptr[q] - 6'd1;
            slot_mem[q][head_ptr[q]] = handle;
            fill[q] = fill[q] + 7'd1;
          end else begin
            slot_mem[q][tail_ptr[q]] = handle;
            tail_ptr[q] = tail_ptr[q] + 6'd1;
            fill[q] = fill[q] + 7'd1;
          end
        end
        default: begin
          if (fill[q] == 0) begin
            r.status = mqd_pkg::ST_EMPTY;
          end else if (op == mqd_pkg::MODE_POP_HEAD) begin
            r.handle = slot_mem[q][head_ptr[q]];
            r.valid  = 1'b1;
            head_ptr[q] = head_ptr[q] + 6'd1;
            fill[q] = fill[q] - 7'd1;
          end else begin
            tail_ptr[q] = tail_ptr[q] - 6'd1;
            r.handle = slot_mem[q][tail_ptr[q]];
            r.valid  = 1'b1;
            fill[q] = fill[q] - 7'd1;
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst) begin
      for (int q = 0; q < BANK_SIZE; q++) begin
        head_ptr[q] = '0;
        tail_ptr[q] = '0;
        fill[q]     = '0;
      end
      queues_in_use = '0;
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (mqd_pkg::reg_index_t'(paddr[2]) == mqd_pkg::REG_QUEUE_COUNT) begin
          queues_in_use = pwdata[4:0];
        end
      end
      if (s_tvalid && s_tready) begin
        results_due.push_back(apply_request(mqd_pkg::mode_t'(s_tuser), s_tdata[3:0],
                                            s_tdata[35:4]));
      end
      if (m_tvalid && m_tready) begin
        got.handle = m_tdata[31:0];
        got.status = mqd_pkg::status_t'(m_tdata[33:32]);
        got.valid  = m_tuser[0];
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result transfer: handle %h valid %0b status %0d",
                   $time, got.handle, got.valid, got.status);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got.handle !== want.handle) begin
            $display("%0t: popped handle expected %h got %h", $time, want.handle, got.handle);
            errors++;
          end
          if (got.valid !== want.valid) begin
            $display("%0t: handle valid expected %0b got %0b", $time, want.valid, got.valid);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors++;
          end
        end
      end
    end
    outstanding <= results_due.size();
    fail_count  <= errors;
  end

endmodule

/* dv/multi_queue_work_stealing_deque_tb.sv */
// testbench top for the multi-queue work-stealing deque: clock, reset, request and
// apb stimulus, random backpressure and the verdict
// depends on mqd_pkg, mqd_result_check and the deque rtl
`timescale 1ns / 1ps

module multi_queue_work_stealing_deque_tb;

  localparam int          LIMIT_CYCLES     = 500000;
  localparam logic [2:0]  ADDR_QUEUE_COUNT = {mqd_pkg::REG_QUEUE_COUNT, 2'b00};
  localparam logic [2:0]  ADDR_UNUSED      = {mqd_pkg::REG_UNUSED, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // queue_id[3:0], task_handle[35:4], zero pad
  logic [1:0]  s_tuser = '0;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // popped_handle[31:0], status[33:32], zero pad
  logic [0:0]  m_tuser;        // handle_valid[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          outstanding;
  int          fail_count;
  int unsigned cycles = 0;
  int unsigned stall_pct = 20;
  int unsigned hold_left = 0;
  bit          steady = 1'b0;

  multi_queue_work_stealing_deque uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mqd_result_check checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .outstanding(outstanding), .fail_count(fail_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side backpressure, mostly short stalls with an occasional long one
  always @(posedge clk) begin
    if (rst || steady) begin
      m_tready  <= !rst;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      m_tready  <= 1'b0;
      hold_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(2, 0);
    end else begin
      m_tready  <= 1'b1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic feed(input mqd_pkg::mode_t op, input logic [3:0] qid,
                      input logic [31:0] handle);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'h0, handle, qid};
    do @(posedge clk); while (!s_tready);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one random phase: a hot queue takes most requests so rings fill and drain
  task automatic run_phase(input logic [4:0] qc, input int unsigned hot,
                           input int unsigned push_pct, input int unsigned items,
                           input int unsigned stall, input bit calm);
    int unsigned    in_use;
    int unsigned    r;
    logic [3:0]     qid;
    logic [31:0]    handle;
    mqd_pkg::mode_t op;
    settle();
    apb_write(ADDR_QUEUE_COUNT, 32'(qc));
    in_use    = (qc > 16) ? 16 : qc;
    steady    = calm;
    stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (in_use == 0 || r >= 93) qid = 4'($urandom_range(15));
      else if (r < 70) qid = 4'(hot);
      else qid = 4'($urandom_range(in_use - 1));
      if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? mqd_pkg::MODE_PUSH_TAIL : mqd_pkg::MODE_PUSH_HEAD;
      end else begin
        op = $urandom_range(1) ? mqd_pkg::MODE_POP_TAIL : mqd_pkg::MODE_POP_HEAD;
      end
      case ($urandom_range(19))
        0: handle = 32'h0000_0000;
        1: handle = 32'hFFFF_FFFF;
        2: handle = 32'h8000_0000;
        default: handle = $urandom();
      endcase
      feed(op, qid, handle);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // queue count is zero after reset, every id rejected
    feed(mqd_pkg::MODE_PUSH_HEAD, 4'd0, 32'h0000_0001);
    settle();
    apb_write(ADDR_UNUSED, 32'd5);
    feed(mqd_pkg::MODE_POP_TAIL, 4'd0, 32'h0000_0000);
    settle();
    apb_write(ADDR_QUEUE_COUNT, 32'd3);
    feed(mqd_pkg::MODE_PUSH_HEAD, 4'd0, 32'hFFFF_FFFF);
    feed(mqd_pkg::MODE_PUSH_TAIL, 4'd0, 32'h0000_0000);
    feed(mqd_pkg::MODE_PUSH_HEAD, 4'd0, 32'hA5A5_A5A5);
    feed(mqd_pkg::MODE_POP_HEAD,  4'd0, 32'h0000_0000);
    feed(mqd_pkg::MODE_POP_TAIL,  4'd0, 32'hFFFF_FFFF);
    feed(mqd_pkg::MODE_POP_TAIL,  4'd0, 32'h0000_0000);
    feed(mqd_pkg::MODE_POP_HEAD,  4'd0, 32'h0000_0000);
    feed(mqd_pkg::MODE_POP_TAIL,  4'd0, 32'h0000_0000);
    feed(mqd_pkg::MODE_PUSH_TAIL, 4'd2, 32'h5A5A_5A5A);
    feed(mqd_pkg::MODE_POP_HEAD,  4'd2, 32'h0000_0000);
    feed(mqd_pkg::MODE_PUSH_HEAD, 4'd3, 32'h1234_5678);
    feed(mqd_pkg::MODE_POP_TAIL,  4'd15, 32'h0000_0000);
    settle();
    // count above the bank size acts as the full bank
    apb_write(ADDR_QUEUE_COUNT, 32'd31);
    feed(mqd_pkg::MODE_PUSH_TAIL, 4'd15, 32'h1234_5678);
    feed(mqd_pkg::MODE_PUSH_HEAD, 4'd15, 32'h8765_4321);
    feed(mqd_pkg::MODE_POP_TAIL,  4'd15, 32'h0000_0000);
    feed(mqd_pkg::MODE_POP_HEAD,  4'd15, 32'h0000_0000);

    run_phase(5'd16, 5,  95, 110, 20, 1'b0);
    run_phase(5'd16, 5,  15, 100, 0,  1'b1);
    run_phase(5'd1,  0,  90, 90,  50, 1'b0);
    run_phase(5'd1,  0,  20, 90,  20, 1'b0);
    run_phase(5'd31, 15, 95, 100, 20, 1'b0);
    run_phase(5'd7,  3,  50, 100, 30, 1'b0);
    run_phase(5'd12, 11, 30, 80,  0,  1'b1);
    run_phase(5'd0,  0,  50, 20,  20, 1'b0);
    run_phase(5'd16, 15, 10, 60,  20, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mqd_pkg.sv
hw/rtl/mqd_front.sv
hw/rtl/mqd_cmd_fifo.sv
hw/rtl/mqd_back.sv
hw/rtl/multi_queue_work_stealing_deque.sv
dv/mqd_result_check.sv
dv/multi_queue_work_stealing_deque_tb.sv
